/* rtl/mcpt_pkg.sv */
// Shared types, codes and constants of the PWM / one-shot timer bank.
package mcpt_pkg;

    localparam int DEF_CHANNELS  = 16;
    localparam int DEF_TIME_BITS = 24;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SET_PWM  = 3'd1,
        CMD_SET_OS   = 3'd2,
        CMD_SET_FOL  = 3'd3,
        CMD_DUTY     = 3'd4,
        CMD_DECONF   = 3'd5,
        CMD_RESET_OS = 3'd6,
        CMD_READ     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_PWM     = 2'd1,
        MODE_ONESHOT = 2'd2,
        MODE_FOLLOW  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_A,
        ST_TICK_B,
        ST_DUTY_MUL,
        ST_DUTY_FOL,
        ST_FOL_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    // Sequencer controls handed to the multiplier.
    typedef struct packed {
        logic        start;
        logic [40:0] a;
        logic [15:0] b;
    } mul_req_t;

endpackage

/* rtl/multi_channel_pwm_one_shot_timer.sv */
// Top level of the multi-channel PWM / one-shot timer bank.
// A tick makes two passes over the channels, ST_TICK_A then ST_TICK_B, one channel per
// cycle, then ST_OUT; a duty write runs ST_DUTY_MUL and ST_FOL_MUL (two partial products),
// ST_DUTY_FOL (one product per channel), ST_SUM and ST_OUT; other commands run ST_SUM and
// ST_OUT. s_tready is low while busy and returns with m_tvalid; a stalled m_tready adds its stall.
// Reset (aresetn low, synchronous) clears all channel state and the output beat.
module multi_channel_pwm_one_shot_timer
    import mcpt_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[2:0], channel[6:3], period_ticks[30:7], duty_q16[47:31],
    // leader[52:48], gain_q8[68:53], trigger_levels[84:69], zero fill
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pin_levels[15:0], fired_mask[31:16], idle_mask[47:32],
    // configured_mask[63:48], read_mode[65:64], read_period[89:66],
    // read_compare[113:90], zero fill
    output logic [119:0] m_tdata
);
    // time width is fixed by the multiplier split (17-bit duty by 24-bit period)
    localparam int TIME_BITS = DEF_TIME_BITS;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NB = TIME_BITS + 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // channel state
    mode_t               mode_reg [CHANNELS];
    logic [TIME_BITS-1:0] per_reg [CHANNELS];
    logic [TIME_BITS-1:0] cmp_reg [CHANNELS];
    logic [4:0]          lead_reg [CHANNELS];
    logic [NB-1:0]       cnt_reg  [CHANNELS];
    logic [CHANNELS-1:0] pin_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg;
    cmd_t  cmd_reg;
    logic [3:0]  ch_reg;
    logic [23:0] per_in_reg;
    logic [16:0] duty_reg;
    logic [4:0]  lead_in_reg;
    logic [15:0] gain_reg;
    logic [15:0] trig_reg;
    logic [40:0] dp_reg;          // duty * period
    logic        m_tvalid_reg;
    logic [119:0] m_tdata_reg;
    logic [119:0] m_tdata_next;

    logic ok;
    logic [CW-1:0] chi;
    logic last_idx;
    mul_req_t req;
    logic [56:0] prod;

    assign ok  = ({1'b0, ch_reg} < 5'(CHANNELS));
    assign chi = ch_reg[CW-1:0];
    assign last_idx = (idx_reg == CW'(CHANNELS - 1));
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    mcpt_mul u_mul (.aclk(aclk), .req(req), .prod(prod));

    always_comb begin
        req.start = 1'b0;
        req.a = '0;
        req.b = '0;
        case (state_reg)
            ST_IDLE: begin
                req.start = s_tvalid;
                req.a = {24'd0, s_tdata[47:31]};
                req.b = 16'(per_reg[s_tdata[3+CW-1:3]]);
            end
            ST_DUTY_MUL: begin
                req.start = 1'b1;
                req.a = {24'd0, duty_reg};
                req.b = 16'(per_reg[chi] >> 16);
            end
            ST_DUTY_FOL: begin
                req.start = 1'b1;
                req.a = dp_reg;
                req.b = per_reg[idx_reg][15:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                state_next = (s_tdata[2:0] == CMD_TICK) ? ST_TICK_A : ST_SUM;
                if (s_tdata[2:0] == CMD_DUTY) state_next = ST_DUTY_MUL;
            end
            ST_TICK_A:   if (last_idx) state_next = ST_TICK_B;
            ST_TICK_B:   if (last_idx) state_next = ST_OUT;
            ST_DUTY_MUL: state_next = ST_FOL_MUL;
            ST_FOL_MUL:  state_next = ST_DUTY_FOL;
            ST_DUTY_FOL: if (last_idx) state_next = ST_SUM;
            ST_SUM:      state_next = ST_OUT;
            ST_OUT:      if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // tick and duty datapath working on channel idx_reg
    logic [NB:0] n_tk;
    logic [NB:0] p2;
    logic [NB-1:0] pl;
    logic [63:0] dtot, ftot;
    assign pl = {1'b0, per_reg[idx_reg]};
    assign p2 = {1'b0, pl} << 1;
    assign n_tk = {1'b0, cnt_reg[idx_reg] + NB'(1)};
    // prod holds dp*gain; ceil(dp*g / 2^24)
    assign ftot = (64'(prod) + 64'hFFFFFF) >> 24;
    // dp=lo16 part*duty added with high part product later
    assign dtot = (64'(dp_reg) + 64'hFFFF) >> 16;

    // status beat built from the current channel state
    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            m_tdata_next[i]      = pin_reg[i];
            m_tdata_next[16 + i] = cnt_reg[i] >= {1'b0, per_reg[i]};
            m_tdata_next[32 + i] = cnt_reg[i] == '0;
            m_tdata_next[48 + i] = mode_reg[i] != MODE_NONE;
        end
        if (ok) begin
            m_tdata_next[65:64]  = mode_reg[chi];
            m_tdata_next[89:66]  = 24'(per_reg[chi]);
            m_tdata_next[113:90] = 24'(cmp_reg[chi]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            pin_reg <= '0;
            idx_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                mode_reg[i] <= MODE_NONE;
                per_reg[i] <= '0;
                cmp_reg[i] <= '0;
                lead_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    cmd_reg <= cmd_t'(s_tdata[2:0]);
                    ch_reg <= s_tdata[6:3];
                    per_in_reg <= s_tdata[30:7];
                    duty_reg <= s_tdata[47:31];
                    lead_in_reg <= s_tdata[52:48];
                    gain_reg <= s_tdata[68:53];
                    trig_reg <= s_tdata[84:69];
                    idx_reg <= '0;
                end
                ST_TICK_A: begin
                    if (mode_reg[idx_reg] == MODE_PWM) begin
                        if (n_tk[NB-1:0] > p2[NB-1:0] || p2[NB] == 1'b0 &&
                            n_tk[NB-1:0] > p2[NB-1:0]) begin
                            cnt_reg[idx_reg] <= '0;
                        end else if (n_tk[NB-1:0] >= pl) begin
                            cnt_reg[idx_reg] <= n_tk[NB-1:0] - pl;
                            if (cmp_reg[idx_reg] != '0) pin_reg[idx_reg] <= 1'b1;
                        end else begin
                            cnt_reg[idx_reg] <= n_tk[NB-1:0];
                            if (n_tk[NB-1:0] >= {1'b0, cmp_reg[idx_reg]})
                                pin_reg[idx_reg] <= 1'b0;
                        end
                    end else if (mode_reg[idx_reg] == MODE_ONESHOT) begin
                        if (trig_reg[idx_reg] || cnt_reg[idx_reg] != '0) begin
                            if (cnt_reg[idx_reg] >= pl) pin_reg[idx_reg] <= 1'b0;
                            else begin
                                cnt_reg[idx_reg] <= n_tk[NB-1:0];
                                pin_reg[idx_reg] <= 1'b1;
                            end
                        end
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + CW'(1);
                end
                ST_TICK_B: begin
                    if (mode_reg[idx_reg] == MODE_FOLLOW) begin
                        if (lead_reg[idx_reg] < 5'(CHANNELS) &&
                            mode_reg[lead_reg[idx_reg][CW-1:0]] == MODE_PWM)
                            pin_reg[idx_reg] <= cnt_reg[lead_reg[idx_reg][CW-1:0]] <
                                                {1'b0, cmp_reg[idx_reg]};
                        else
                            pin_reg[idx_reg] <= 1'b0;
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + CW'(1);
                end
                ST_DUTY_MUL: dp_reg <= 41'(prod);        // duty * period[15:0]
                ST_FOL_MUL: begin
                    dp_reg <= dp_reg + (41'(prod) << 16); // + duty * period[hi]
                end
                ST_DUTY_FOL: begin
                    if (idx_reg == '0 && ok && mode_reg[chi] == MODE_PWM) begin
                        cmp_reg[chi] <= (dtot > 64'(TMAX)) ? TMAX : TIME_BITS'(dtot);
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + CW'(1);
                end
                ST_SUM: begin
                    if (ok) begin
                        case (cmd_reg)
                            CMD_SET_PWM: begin
                                mode_reg[chi] <= MODE_PWM;
                                per_reg[chi] <= TIME_BITS'(per_in_reg);
                            end
                            CMD_SET_OS: begin
                                mode_reg[chi] <= MODE_ONESHOT;
                                per_reg[chi] <= TIME_BITS'(per_in_reg);
                            end
                            CMD_SET_FOL: begin
                                mode_reg[chi] <= MODE_FOLLOW;
                                lead_reg[chi] <= lead_in_reg;
                                per_reg[chi] <= TIME_BITS'(gain_reg);
                            end
                            CMD_DECONF: mode_reg[chi] <= MODE_NONE;
                            CMD_RESET_OS: begin
                                cnt_reg[chi] <= '0;
                                pin_reg[chi] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
            // follower compare is written in the cycle after its product is started
            if (state_reg == ST_DUTY_FOL && idx_reg != '0) begin
                if (ok && mode_reg[chi] == MODE_PWM &&
                    mode_reg[idx_reg - CW'(1)] == MODE_FOLLOW &&
                    lead_reg[idx_reg - CW'(1)] == {1'b0, ch_reg})
                    cmp_reg[idx_reg - CW'(1)] <= (ftot > 64'(TMAX)) ? TMAX
                                                                    : TIME_BITS'(ftot);
            end
            if (state_reg == ST_SUM && cmd_reg == CMD_DUTY && ok &&
                mode_reg[chi] == MODE_PWM &&
                mode_reg[CHANNELS-1] == MODE_FOLLOW &&
                lead_reg[CHANNELS-1] == {1'b0, ch_reg})
                cmp_reg[CHANNELS-1] <= (ftot > 64'(TMAX)) ? TMAX : TIME_BITS'(ftot);
            // output beat: load when the slot is free, clear on handshake
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= m_tdata_next;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("beat dropped");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> idx_reg == '0 || state_reg == ST_IDLE)
        else $error("index not cleared");
`endif
endmodule

/* rtl/mcpt_mul.sv */
// Shared registered multiplier: 41 by 16 bits split into 21x16 and 20x16 halves.
module mcpt_mul
    import mcpt_pkg::*;
(
    input  logic        aclk,
    input  mul_req_t    req,
    output logic [56:0] prod
);
    logic [36:0] lo_reg;
    logic [35:0] hi_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            lo_reg <= {16'd0, req.a[20:0]} * {21'd0, req.b};
            hi_reg <= {16'd0, req.a[40:21]} * {20'd0, req.b};
        end
    end

    assign prod = {21'd0, hi_reg} * 57'd2097152 + {20'd0, lo_reg};
endmodule
